// File: rtl/tcsa_pkg.sv
package tcsa_pkg;

  localparam int unsigned SLOTS_PER_CLASS = 4096;
  localparam int unsigned SLOT_W = $clog2(SLOTS_PER_CLASS);
  localparam int unsigned CNT_W = $clog2(SLOTS_PER_CLASS + 1);

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned SLOT_IDX_W = 12;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned SMALL_LIMIT = 64;
  localparam int unsigned SMALL_SHIFT = 6;
  localparam int unsigned LARGE_SHIFT = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE = 1'b1;

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic CLS_SMALL = 1'b0;
  localparam logic CLS_LARGE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EXHAUSTED,
    ST_OUT_OF_RANGE,
    ST_FULL
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic commit;
  } tcsa_cmd_t;

endpackage

// File: rtl/tcsa_ram.sv
module tcsa_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcsa_ctrl.sv
module tcsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  output tcsa_pkg::tcsa_cmd_t cmd_o
);

  import tcsa_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.commit;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        busy         = 1'b1;
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

// File: rtl/tcsa_dp.sv
module tcsa_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcsa_pkg::tcsa_cmd_t                 cmd_i,
  input  logic                                cfg_we_i,
  input  logic [tcsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tcsa_pkg::ADDR_W-1:0]         cfg_wdata_i,
  input  logic                                action_i,
  input  logic [tcsa_pkg::SIZE_W-1:0]         object_size_i,
  input  logic [tcsa_pkg::ADDR_W-1:0]         release_address_i,
  output logic [tcsa_pkg::ADDR_W-1:0]         granted_address_o,
  output logic [tcsa_pkg::SLOT_IDX_W-1:0]     slot_index_o,
  output logic                                size_class_o,
  output logic [1:0]                          status_o
);

  import tcsa_pkg::*;

  logic [ADDR_W-1:0] small_base_q, large_base_q;
  logic [CNT_W-1:0]  small_cnt_q, small_cnt_d, large_cnt_q, large_cnt_d;
  logic [CNT_W-1:0]  small_fresh_q, small_fresh_d, large_fresh_q, large_fresh_d;

  logic              act_q, cls_q;
  logic [ADDR_W-1:0] addr_q;

  logic [ADDR_W-1:0]     granted_q, granted_d;
  logic [SLOT_IDX_W-1:0] slot_idx_q, slot_idx_d;
  logic                  cls_out_q;
  status_e               status_q, status_d;

  logic [CNT_W-1:0]  small_cnt_m1, large_cnt_m1;
  logic [SLOT_W-1:0] small_rdata, large_rdata;

  logic [CNT_W-1:0]  cnt, fresh, cnt_d, fresh_d;
  logic [ADDR_W-1:0] base, diff, s_wide, slot_off;
  logic [SLOT_W-1:0] top_slot, slot, rel_slot;
  logic              push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_base_q  <= '0;
      large_base_q  <= '0;
      small_cnt_q   <= '0;
      large_cnt_q   <= '0;
      small_fresh_q <= '0;
      large_fresh_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_SMALL_BASE) begin
        small_base_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_LARGE_BASE) begin
        large_base_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        small_cnt_q   <= small_cnt_d;
        large_cnt_q   <= large_cnt_d;
        small_fresh_q <= small_fresh_d;
        large_fresh_q <= large_fresh_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      cls_q  <= (object_size_i <= SIZE_W'(SMALL_LIMIT)) ? CLS_SMALL : CLS_LARGE;
      addr_q <= release_address_i;
    end
    if (cmd_i.commit) begin
      granted_q  <= granted_d;
      slot_idx_q <= slot_idx_d;
      cls_out_q  <= cls_q;
      status_q   <= status_d;
    end
  end

  // read both stack tops while the item is taken in
  assign small_cnt_m1 = small_cnt_q - CNT_W'(1);
  assign large_cnt_m1 = large_cnt_q - CNT_W'(1);

  tcsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS_PER_CLASS)
  ) u_small_stack (
    .clk_i   (clk_i),
    .we_i    (push && cls_q == CLS_SMALL),
    .waddr_i (cnt[SLOT_W-1:0]),
    .wdata_i (rel_slot),
    .re_i    (cmd_i.load),
    .raddr_i (small_cnt_m1[SLOT_W-1:0]),
    .rdata_o (small_rdata)
  );

  tcsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS_PER_CLASS)
  ) u_large_stack (
    .clk_i   (clk_i),
    .we_i    (push && cls_q == CLS_LARGE),
    .waddr_i (cnt[SLOT_W-1:0]),
    .wdata_i (rel_slot),
    .re_i    (cmd_i.load),
    .raddr_i (large_cnt_m1[SLOT_W-1:0]),
    .rdata_o (large_rdata)
  );

  always_comb begin
    cnt      = (cls_q == CLS_LARGE) ? large_cnt_q   : small_cnt_q;
    fresh    = (cls_q == CLS_LARGE) ? large_fresh_q : small_fresh_q;
    base     = (cls_q == CLS_LARGE) ? large_base_q  : small_base_q;
    top_slot = (cls_q == CLS_LARGE) ? large_rdata   : small_rdata;

    diff     = addr_q - base;
    s_wide   = (cls_q == CLS_LARGE) ? (diff >> LARGE_SHIFT) : (diff >> SMALL_SHIFT);
    rel_slot = s_wide[SLOT_W-1:0];

    cnt_d    = cnt;
    fresh_d  = fresh;
    slot     = '0;
    status_d = ST_OK;
    push     = 1'b0;

    if (act_q == ACT_ACQUIRE) begin
      if (cnt != '0 && cnt <= CNT_W'(SLOTS_PER_CLASS)) begin
        cnt_d = cnt - CNT_W'(1);
        slot  = top_slot;
      end else if (fresh < CNT_W'(SLOTS_PER_CLASS)) begin
        // never-issued slots sit below the released ones
        slot    = fresh[SLOT_W-1:0];
        fresh_d = fresh + CNT_W'(1);
      end else begin
        status_d = ST_EXHAUSTED;
      end
    end else begin
      if (addr_q < base || s_wide >= ADDR_W'(SLOTS_PER_CLASS)) begin
        status_d = ST_OUT_OF_RANGE;
      end else if (cnt >= fresh || cnt >= CNT_W'(SLOTS_PER_CLASS)) begin
        status_d = ST_FULL;
        slot     = rel_slot;
      end else begin
        push  = cmd_i.commit;
        cnt_d = cnt + CNT_W'(1);
        slot  = rel_slot;
      end
    end

    slot_off = (cls_q == CLS_LARGE) ? (ADDR_W'(slot) << LARGE_SHIFT)
                                    : (ADDR_W'(slot) << SMALL_SHIFT);
    if (act_q == ACT_ACQUIRE && status_d == ST_OK) begin
      granted_d = base + slot_off;
    end else begin
      granted_d = '0;
    end
    slot_idx_d = SLOT_IDX_W'(slot);

    small_cnt_d   = (cls_q == CLS_SMALL) ? cnt_d   : small_cnt_q;
    large_cnt_d   = (cls_q == CLS_LARGE) ? cnt_d   : large_cnt_q;
    small_fresh_d = (cls_q == CLS_SMALL) ? fresh_d : small_fresh_q;
    large_fresh_d = (cls_q == CLS_LARGE) ? fresh_d : large_fresh_q;
  end

  assign granted_address_o = granted_q;
  assign slot_index_o      = slot_idx_q;
  assign size_class_o      = cls_out_q;
  assign status_o          = status_q;

endmodule

// File: rtl/two_class_slot_allocator.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------------
// request   | start / busy         | action_i, object_size_i, release_address_i
// result    | done_o (one cycle)   | granted_address_o, slot_index_o, size_class_o,
//           |                      | status_o
// config    | cfg_we_i, cfg_idx_i  | cfg_wdata_i
//
// An item is taken when start is high and busy low; the stack top of both classes is
// read from the slot RAMs in that cycle. The next cycle commits the pop or push and
// the counters, and the result shows with done_o in the cycle after that.
// No new item is taken until the previous one commits; busy is high while it commits.
// Reset clears the counters and region bases; the stack RAMs need no clearing.
// Results cannot be held off: done_o lasts exactly one cycle.
module two_class_slot_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic [tcsa_pkg::SIZE_W-1:0]         object_size_i,
  input  logic [tcsa_pkg::ADDR_W-1:0]         release_address_i,
  output logic                                done_o,
  output logic [tcsa_pkg::ADDR_W-1:0]         granted_address_o,
  output logic [tcsa_pkg::SLOT_IDX_W-1:0]     slot_index_o,
  output logic                                size_class_o,
  output logic [1:0]                          status_o,
  input  logic                                cfg_we_i,
  input  logic [tcsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tcsa_pkg::ADDR_W-1:0]         cfg_wdata_i
);

  import tcsa_pkg::*;

  tcsa_cmd_t cmd;

  tcsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  tcsa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .action_i          (action_i),
    .object_size_i     (object_size_i),
    .release_address_i (release_address_i),
    .granted_address_o (granted_address_o),
    .slot_index_o      (slot_index_o),
    .size_class_o      (size_class_o),
    .status_o          (status_o)
  );

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import tcsa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]     addr;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  cls;
    status_e               status;
  } alloc_res_t;

  typedef struct packed {
    logic              cls;
    logic [ADDR_W-1:0] addr;
  } held_t;

  // on a register row, act carries the register index and addr the data
  typedef struct {
    logic              is_cfg;
    logic              act;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              typed;
    alloc_res_t        res;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   action_i = ACT_ACQUIRE;
  logic [SIZE_W-1:0]      object_size_i = '0;
  logic [ADDR_W-1:0]      release_address_i = '0;
  logic                   done_o;
  logic [ADDR_W-1:0]      granted_address_o;
  logic [SLOT_IDX_W-1:0]  slot_index_o;
  logic                   size_class_o;
  logic [1:0]             status_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = CFG_SMALL_BASE;
  logic [ADDR_W-1:0]      cfg_wdata_i = '0;

  two_class_slot_allocator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .object_size_i     (object_size_i),
    .release_address_i (release_address_i),
    .done_o            (done_o),
    .granted_address_o (granted_address_o),
    .slot_index_o      (slot_index_o),
    .size_class_o      (size_class_o),
    .status_o          (status_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  // allocator state as the block should hold it
  logic [SLOT_W-1:0] free_slots [2][SLOTS_PER_CLASS];
  int unsigned       stack_cnt [2] = '{0, 0};
  int unsigned       fresh_next [2] = '{0, 0};
  logic [ADDR_W-1:0] region_base [2] = '{'0, '0};

  alloc_res_t  due_q [$];
  held_t       held_q [$];
  alloc_res_t  pend_res = '0;
  logic        pend_typed = 1'b0;
  logic        no_gap = 1'b0;
  int unsigned mismatches = 0;
  row_t        dir_rows [24];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic alloc_res_t predict_alloc(logic act, logic [SIZE_W-1:0] size,
                                               logic [ADDR_W-1:0] addr);
    alloc_res_t        r;
    logic              c;
    int unsigned       sh;
    logic [ADDR_W-1:0] s;
    c = (size <= SIZE_W'(SMALL_LIMIT)) ? CLS_SMALL : CLS_LARGE;
    sh = (c == CLS_LARGE) ? LARGE_SHIFT : SMALL_SHIFT;
    s = '0;
    r = '{addr: '0, slot: '0, cls: c, status: ST_OK};
    if (act == ACT_ACQUIRE) begin
      // released slots sit above the never-issued ones
      if (stack_cnt[c] > 0) begin
        stack_cnt[c]--;
        s = ADDR_W'(free_slots[c][stack_cnt[c]]);
      end else if (fresh_next[c] < SLOTS_PER_CLASS) begin
        s = ADDR_W'(fresh_next[c]);
        fresh_next[c]++;
      end else begin
        r.status = ST_EXHAUSTED;
      end
      if (r.status == ST_OK) r.addr = region_base[c] + (s << sh);
    end else begin
      s = (addr - region_base[c]) >> sh;
      if (addr < region_base[c] || s >= ADDR_W'(SLOTS_PER_CLASS)) begin
        r.status = ST_OUT_OF_RANGE;
        s = '0;
      end else if (stack_cnt[c] >= fresh_next[c] || stack_cnt[c] >= SLOTS_PER_CLASS) begin
        r.status = ST_FULL;
      end else begin
        free_slots[c][stack_cnt[c]] = s[SLOT_W-1:0];
        stack_cnt[c]++;
      end
    end
    r.slot = s[SLOT_IDX_W-1:0];
    return r;
  endfunction

  task automatic report_bad(string what, alloc_res_t want, alloc_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: expected addr %h slot %0d class %0d status %0d,",
                " got addr %h slot %0d class %0d status %0d"},
               $realtime, what, want.addr, want.slot, want.cls, want.status,
               got.addr, got.slot, got.cls, got.status);
  endtask

  always @(posedge clk_i) begin
    alloc_res_t got;
    alloc_res_t want;
    alloc_res_t pred;
    if (rst_ni) begin
      if (done_o) begin
        got = '{granted_address_o, slot_index_o, size_class_o, status_e'(status_o)};
        if (due_q.size() == 0) begin
          report_bad("result with no item due", '0, got);
        end else begin
          want = due_q.pop_front();
          if (got.addr !== want.addr || got.slot !== want.slot || got.cls !== want.cls ||
              got.status !== want.status)
            report_bad("result mismatch", want, got);
        end
      end
      if (start && !busy) begin
        pred = predict_alloc(action_i, object_size_i, release_address_i);
        if (action_i == ACT_ACQUIRE && pred.status == ST_OK)
          held_q.push_back('{pred.cls, pred.addr});
        due_q.push_back(pend_typed ? pend_res : pred);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gap) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(logic c);
    if (c == CLS_LARGE) return SIZE_W'($urandom_range(65, 511));
    return SIZE_W'($urandom_range(0, 64));
  endfunction

  task automatic send_item(logic act, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr,
                           logic typed, alloc_res_t res);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    action_i          <= act;
    object_size_i     <= size;
    release_address_i <= addr;
    pend_typed        <= typed;
    pend_res          <= res;
    // hold the item until the edge that takes it
    @(posedge clk_i iff !busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    region_base[idx] = data;
    // held addresses belong to the old region
    held_q.delete();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned n);
    logic              c;
    logic              act;
    logic [ADDR_W-1:0] a;
    held_t             h;
    int unsigned       k;
    int unsigned       r;
    int unsigned       sh;
    repeat (n) begin
      r = $urandom_range(0, 99);
      c = 1'($urandom_range(0, 1));
      a = {$urandom, $urandom};
      act = ACT_RELEASE;
      if (r < 50) begin
        act = ACT_ACQUIRE;
      end else if (r < 85 && held_q.size() != 0) begin
        // hand back a live slot, offset somewhere inside it
        k = $urandom_range(0, held_q.size() - 1);
        h = held_q[k];
        held_q.delete(k);
        c = h.cls;
        sh = (c == CLS_LARGE) ? LARGE_SHIFT : SMALL_SHIFT;
        a = h.addr + ADDR_W'($urandom_range(0, (1 << sh) - 1));
      end else begin
        sh = (c == CLS_LARGE) ? LARGE_SHIFT : SMALL_SHIFT;
        case ($urandom_range(0, 3))
          0: ;
          1: a = region_base[c] + (ADDR_W'($urandom_range(0, 2 * SLOTS_PER_CLASS - 1)) << sh);
          2: a = region_base[c] - ADDR_W'($urandom_range(1, 1024));
          default: begin
            // release a slot that is still live: duplicate
            if (held_q.size() != 0) begin
              h = held_q[$urandom_range(0, held_q.size() - 1)];
              c = h.cls;
              a = h.addr;
            end
          end
        endcase
      end
      send_item(act, pick_size(c), a, 1'b0, '0);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] sb;
    logic [ADDR_W-1:0] lb;
    dir_rows = '{
      '{1'b0, ACT_ACQUIRE, 9'd1,   64'h0,      1'b1, '{64'h0,   12'd0, CLS_SMALL, ST_OK}},
      '{1'b0, ACT_ACQUIRE, 9'd64,  64'h0,      1'b1, '{64'h40,  12'd1, CLS_SMALL, ST_OK}},
      '{1'b0, ACT_ACQUIRE, 9'd65,  64'h0,      1'b1, '{64'h0,   12'd0, CLS_LARGE, ST_OK}},
      '{1'b0, ACT_ACQUIRE, 9'd256, 64'h0,      1'b1, '{64'h100, 12'd1, CLS_LARGE, ST_OK}},
      '{1'b0, ACT_ACQUIRE, 9'd0,   64'h0,      1'b1, '{64'h80,  12'd2, CLS_SMALL, ST_OK}},
      '{1'b0, ACT_ACQUIRE, 9'd511, 64'h0,      1'b1, '{64'h200, 12'd2, CLS_LARGE, ST_OK}},
      '{1'b0, ACT_RELEASE, 9'd1,   64'h40,     1'b1, '{64'h0,   12'd1, CLS_SMALL, ST_OK}},
      '{1'b0, ACT_RELEASE, 9'd64,  64'h7f,     1'b1, '{64'h0,   12'd1, CLS_SMALL, ST_OK}},
      '{1'b0, ACT_RELEASE, 9'd2,   64'h80,     1'b1, '{64'h0,   12'd2, CLS_SMALL, ST_OK}},
      '{1'b0, ACT_RELEASE, 9'd3,   64'h0,      1'b1, '{64'h0,   12'd0, CLS_SMALL, ST_FULL}},
      '{1'b0, ACT_ACQUIRE, 9'd5,   64'h0,      1'b0, '0},
      '{1'b0, ACT_RELEASE, 9'd300, 64'h100000, 1'b1,
        '{64'h0, 12'd0, CLS_LARGE, ST_OUT_OF_RANGE}},
      '{1'b0, ACT_RELEASE, 9'd511, '1,         1'b1,
        '{64'h0, 12'd0, CLS_LARGE, ST_OUT_OF_RANGE}},
      '{1'b0, ACT_RELEASE, 9'd0,   64'h3ffff,  1'b0, '0},
      '{1'b0, ACT_RELEASE, 9'd200, 64'h1ff,    1'b0, '0},
      '{1'b0, ACT_RELEASE, 9'd65,  64'h300,    1'b0, '0},
      '{1'b0, ACT_ACQUIRE, 9'd100, 64'h0,      1'b0, '0},
      '{1'b1, CFG_SMALL_BASE, 9'd0, '1,        1'b0, '0},
      '{1'b1, CFG_LARGE_BASE, 9'd0, 64'hffff_ffff_ffff_ff00, 1'b0, '0},
      '{1'b0, ACT_ACQUIRE, 9'd64,  64'h0,      1'b0, '0},
      '{1'b0, ACT_RELEASE, 9'd9,   64'h0,      1'b1,
        '{64'h0, 12'd0, CLS_SMALL, ST_OUT_OF_RANGE}},
      '{1'b0, ACT_RELEASE, 9'd10,  '1,         1'b0, '0},
      '{1'b0, ACT_RELEASE, 9'd70,  '1,         1'b0, '0},
      '{1'b0, ACT_ACQUIRE, 9'd256, 64'h0,      1'b0, '0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_reg(dir_rows[i].act, dir_rows[i].addr);
      else
        send_item(dir_rows[i].act, dir_rows[i].size, dir_rows[i].addr,
                  dir_rows[i].typed, dir_rows[i].res);
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          sb = '0;
          lb = '1;
        end
        2: begin
          sb = '1;
          lb = '0;
        end
        default: begin
          sb = {$urandom, $urandom};
          lb = {$urandom, $urandom};
          if ($urandom_range(0, 1) == 1) begin
            sb[7:0] = '0;
            lb[7:0] = '0;
          end
        end
      endcase
      write_reg(CFG_SMALL_BASE, sb);
      write_reg(CFG_LARGE_BASE, lb);
      no_gap = (ph == 3);
      run_random(85);
    end

    no_gap = 1'b0;
    run_random(60);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
